>>> hdl/gtl_pkg.sv
// Shared types and constants for the grid tile layout block.
`timescale 1ns / 1ps
`default_nettype none

package gtl_pkg;

  // Shared divider: signed dividend, unsigned divisor no wider than a screen size.
  localparam int DIV_NW = 32;
  localparam int DIV_DW = 13;

  // Internal signed width for pads, running positions and products.
  localparam int DW  = 40;
  // Signed widths of the inner tile width and height.
  localparam int W_W = 16;
  localparam int H_W = 29;

  typedef logic signed [DW-1:0] sdw_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_OUTER_MARGIN = 2'd0;
  localparam logic [1:0] CFG_TILE_GAP     = 2'd1;
  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd2;

  // Sequencer states, one-hot.
  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_GRID  = 18'h00002,
    S_FC    = 18'h00004,
    S_GC    = 18'h00008,
    S_WDIV  = 18'h00010,
    S_WWAIT = 18'h00020,
    S_WSH   = 18'h00040,
    S_HDIV  = 18'h00080,
    S_HWAIT = 18'h00100,
    S_XC    = 18'h00200,
    S_HPAD  = 18'h00400,
    S_YC    = 18'h00800,
    S_VPAD  = 18'h01000,
    S_LC    = 18'h02000,
    S_LX    = 18'h04000,
    S_LG    = 18'h08000,
    S_LPAD  = 18'h10000,
    S_EMIT  = 18'h20000
  } state_t;

endpackage

`default_nettype wire

>>> hdl/gtl_div.sv
// Radix-2 restoring divider with truncation toward zero, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module gtl_div import gtl_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [DIV_NW-1:0] dividend,
  input  wire logic        [DIV_DW-1:0] divisor,
  output logic                          done,
  output logic signed      [DIV_NW-1:0] quotient
);

  localparam int CW = $clog2(DIV_NW);

  logic              active;
  logic [CW-1:0]     cnt;
  logic [DIV_DW-1:0] rem;
  logic [DIV_NW-1:0] quo;
  logic [DIV_DW-1:0] dvs;
  logic              neg;
  logic              zero;
  logic [DIV_DW:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem, quo[DIV_NW-1]} - {1'b0, dvs};
    fits  = ~trial[DIV_DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= '0;
        rem    <= '0;
        quo    <= dividend[DIV_NW-1] ? DIV_NW'(-dividend) : DIV_NW'(dividend);
        dvs    <= divisor;
        neg    <= dividend[DIV_NW-1];
        zero   <= (divisor == '0);
      end else if (active) begin
        rem <= fits ? trial[DIV_DW-1:0] : {rem[DIV_DW-2:0], quo[DIV_NW-1]};
        quo <= {quo[DIV_NW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DIV_NW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // A zero divisor yields a zero quotient.
  assign quotient = zero ? '0 : (neg ? -$signed(quo) : $signed(quo));

endmodule

`default_nettype wire

>>> hdl/grid_tile_layout.sv
// Top level of the grid tile layout block: sequencer, shared multiplier, shared divider and tile emitter.
// Flow: a request runs the grid search, two divisions on the shared divider and the remaining sequencer
// steps before the first tile, then one tile per cycle while out_stall is low.
// Throughput: one request at a time; the shared divider and multiplier set the setup time.
// Reset: synchronous, active high; registers return to margin 16, gap 16, frame 8, and the
// sequencer and the output register go empty.
`timescale 1ns / 1ps
`default_nettype none

module grid_tile_layout import gtl_pkg::*; #(
  parameter int MAX_TILES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic        [12:0] screen_width,
  input  wire logic        [12:0] screen_height,
  input  wire logic        [6:0]  tile_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed      [14:0] tile_x,
  output logic signed      [14:0] tile_y,
  output logic signed      [13:0] tile_w,
  output logic signed      [13:0] tile_h,
  output logic                    last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [9:0]  cfg_data
);

  // Counts of tiles, rows and columns all fit the width of the saturated count.
  localparam int CNT_W = $clog2(MAX_TILES + 1);

  state_t state;

  // Configuration registers.
  logic [9:0] outer_margin;
  logic [9:0] tile_gap;
  logic [7:0] frame_width;

  // Request captured at the input transfer.
  logic [12:0]      sw;
  logic [12:0]      sh;
  logic [CNT_W-1:0] n_eff;

  // Grid search state. The product rows*cols is tracked incrementally.
  logic [CNT_W-1:0]   rows;
  logic [CNT_W-1:0]   cols;
  logic [2*CNT_W-1:0] prod;

  // Layout values worked out by the sequencer.
  logic signed [W_W-1:0] w;
  logic signed [H_W-1:0] h;
  sdw_t                  acc;
  sdw_t                  gapc;
  sdw_t                  hpad;
  sdw_t                  vpad;
  sdw_t                  hpad_last;
  logic [CNT_W-1:0]      lastc;

  // Shared multiplier with a registered product.
  logic signed [31:0] mul_a;
  logic signed [13:0] mul_b;
  sdw_t               mq;

  // Shared divider.
  logic                     div_start;
  logic signed [DIV_NW-1:0] div_dividend;
  logic        [DIV_DW-1:0] div_divisor;
  logic                     div_done;
  logic signed [DIV_NW-1:0] div_q;

  // Emitter state.
  logic [CNT_W-1:0] row;
  logic [CNT_W-1:0] col;
  logic [CNT_W-1:0] k;
  sdw_t             x_run;
  sdw_t             y_run;

  // Sign-extended copies of the operands used in the layout sums.
  sdw_t sw_s, sh_s, pad_s, gap_s, fr2_s, w_s, h_s, pitch_x, pitch_y;

  // Halving with truncation toward zero.
  function automatic sdw_t half_tz(sdw_t v);
    sdw_t t;
    t = v + sdw_t'(v[DW-1]);
    return t >>> 1;
  endfunction

  always_comb begin
    sw_s    = sdw_t'($signed({1'b0, sw}));
    sh_s    = sdw_t'($signed({1'b0, sh}));
    pad_s   = sdw_t'($signed({1'b0, outer_margin}));
    gap_s   = sdw_t'($signed({1'b0, tile_gap}));
    fr2_s   = sdw_t'($signed({1'b0, frame_width, 1'b0}));
    w_s     = sdw_t'(w);
    h_s     = sdw_t'(h);
    pitch_x = fr2_s + w_s + gap_s;
    pitch_y = fr2_s + h_s + gap_s;
  end

  // The multiplier takes its operands from the current sequencer step. Counts and the screen height ride
  // on the narrow operand and the wide sums on the other; in the VPAD step both operands are counts.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FC: begin
        mul_a = 32'(fr2_s);
        mul_b = 14'($signed({1'b0, cols}));
      end
      S_GC: begin
        mul_a = 32'(gap_s);
        mul_b = 14'($signed({1'b0, cols - 1'b1}));
      end
      S_WSH: begin
        mul_a = 32'(w_s);
        mul_b = 14'($signed({1'b0, sh}));
      end
      S_XC: begin
        mul_a = 32'(fr2_s + w_s);
        mul_b = 14'($signed({1'b0, cols}));
      end
      S_HPAD: begin
        mul_a = 32'(fr2_s + h_s);
        mul_b = 14'($signed({1'b0, rows}));
      end
      S_YC: begin
        mul_a = 32'(gap_s);
        mul_b = 14'($signed({1'b0, rows - 1'b1}));
      end
      S_VPAD: begin
        mul_a = 32'($signed({1'b0, rows - 1'b1}));
        mul_b = 14'($signed({1'b0, cols}));
      end
      S_LX: begin
        mul_a = 32'(fr2_s + w_s);
        mul_b = 14'($signed({1'b0, lastc}));
      end
      S_LG: begin
        mul_a = 32'(gap_s);
        mul_b = 14'($signed({1'b0, lastc - 1'b1}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mq <= sdw_t'(mul_a * mul_b);
  end

  // The divider first splits the free width over the columns, then scales the height.
  always_comb begin
    div_start    = (state == S_WDIV) || (state == S_HDIV);
    div_dividend = (state == S_WDIV) ? DIV_NW'(acc - mq) : DIV_NW'(mq);
    div_divisor  = (state == S_WDIV) ? DIV_DW'(cols) : sw;
  end

  gtl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  // New requests are taken only while the sequencer is idle. A finished tile may still be
  // waiting in the output register at that point.
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      outer_margin <= 10'd16;
      tile_gap     <= 10'd16;
      frame_width  <= 8'd8;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_OUTER_MARGIN: outer_margin <= cfg_data;
          CFG_TILE_GAP:     tile_gap     <= cfg_data;
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data[7:0];
          default: ;
        endcase
      end

      // While emitting, a consumed tile is replaced at once by the emitter below.
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sw   <= screen_width;
            sh   <= screen_height;
            rows <= CNT_W'(1);
            cols <= CNT_W'(1);
            prod <= (2*CNT_W)'(1);
            if (32'(tile_count) > MAX_TILES) begin
              n_eff <= CNT_W'(MAX_TILES);
            end else begin
              n_eff <= CNT_W'(tile_count);
            end
            // A request for no tiles produces nothing.
            if (tile_count != 7'd0) begin
              state <= S_GRID;
            end
          end
        end
        // Grow the grid: a column when it is square, otherwise a row.
        S_GRID: begin
          if ((2*CNT_W)'(n_eff) > prod) begin
            if (rows == cols) begin
              cols <= cols + 1'b1;
              prod <= prod + (2*CNT_W)'(rows);
            end else begin
              rows <= rows + 1'b1;
              prod <= prod + (2*CNT_W)'(cols);
            end
          end else begin
            state <= S_FC;
          end
        end
        S_FC: begin
          state <= S_GC;
        end
        S_GC: begin
          acc   <= sw_s - (pad_s <<< 1) - mq;
          state <= S_WDIV;
        end
        S_WDIV: begin
          gapc  <= mq;
          state <= S_WWAIT;
        end
        S_WWAIT: begin
          if (div_done) begin
            // Rounding down to a multiple of 8 clears the three low bits.
            w     <= {div_q[W_W-1:3], 3'b000};
            state <= S_WSH;
          end
        end
        S_WSH: begin
          state <= S_HDIV;
        end
        S_HDIV: begin
          state <= S_HWAIT;
        end
        S_HWAIT: begin
          if (div_done) begin
            h     <= div_q[H_W-1:0];
            state <= S_XC;
          end
        end
        S_XC: begin
          state <= S_HPAD;
        end
        S_HPAD: begin
          hpad  <= half_tz(sw_s - mq - gapc);
          state <= S_YC;
        end
        S_YC: begin
          acc   <= sh_s - mq;
          state <= S_VPAD;
        end
        S_VPAD: begin
          vpad  <= half_tz(acc - mq);
          state <= S_LC;
        end
        S_LC: begin
          // Tiles left over for the bottom row.
          lastc <= CNT_W'(sdw_t'(n_eff) - mq);
          state <= S_LX;
        end
        S_LX: begin
          state <= S_LG;
        end
        S_LG: begin
          acc   <= sw_s - mq;
          state <= S_LPAD;
        end
        S_LPAD: begin
          hpad_last <= half_tz(acc - mq);
          row       <= '0;
          col       <= '0;
          k         <= '0;
          y_run     <= vpad;
          // With a single row the bottom row's centering applies at once.
          x_run     <= (rows == CNT_W'(1)) ? half_tz(acc - mq) : hpad;
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            tile_x    <= x_run[14:0];
            tile_y    <= y_run[14:0];
            tile_w    <= w[13:0];
            tile_h    <= h[13:0];
            last      <= (k == n_eff - 1'b1);
            if (k == n_eff - 1'b1) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              if (col == cols - 1'b1) begin
                col   <= '0;
                row   <= row + 1'b1;
                y_run <= y_run + pitch_y;
                x_run <= (row + 1'b1 == rows - 1'b1) ? hpad_last : hpad;
              end else begin
                col   <= col + 1'b1;
                x_run <= x_run + pitch_x;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
